// ===== rtl/core/gql_pkg.sv =====
// gql_pkg: shared types, codes and saturation helpers for the glyph quad layout block.
// No dependencies; imported by the channel interfaces and the top level.
`timescale 1ns / 1ps

package gql_pkg;

    // Request actions
    typedef logic [1:0] t_action;
    localparam t_action ACT_WRITE = 2'd0;
    localparam t_action ACT_START = 2'd1;
    localparam t_action ACT_DRAW  = 2'd2;

    // Configuration register indexes
    typedef logic [1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_INV_W  = 2'd0;
    localparam t_cfg_idx CFG_HEIGHT = 2'd1;
    localparam t_cfg_idx CFG_INV_H  = 2'd2;

    localparam int CFG_DATA_W = 24;

    // Fixed codes and reset values
    localparam logic [7:0]  SPACE_CODE   = 8'd32;
    localparam logic [15:0] SCALE_ONE    = 16'd256;
    localparam logic [23:0] INV_RESET    = 24'd65536;
    localparam logic [12:0] HEIGHT_RESET = 13'd256;

    // One glyph table entry
    typedef struct packed {
        logic [11:0]       ax;
        logic [11:0]       ay;
        logic [7:0]        w;
        logic [7:0]        h;
        logic signed [7:0] ox;
        logic signed [7:0] oy;
        logic [7:0]        adv;
    } t_glyph;

    // Clamp a 34-bit signed sum to the signed 32-bit range
    function automatic logic [31:0] sat32(input logic [33:0] v);
        logic [31:0] r;
        if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
            r = v[31:0];
        end else if (v[33]) begin
            r = 32'h8000_0000;
        end else begin
            r = 32'h7FFF_FFFF;
        end
        return r;
    endfunction

    // Texel count times Q0.24 reciprocal, shifted to Q0.16 and clamped
    function automatic logic [15:0] tex_sat(input logic [36:0] p);
        logic [15:0] r;
        if (p[36:24] != 13'd0) begin
            r = 16'hFFFF;
        end else begin
            r = p[23:8];
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/gql_in_if.sv =====
// gql_in_if: request channel into the glyph quad layout block.
// Depends on gql_pkg for the action type.
`timescale 1ns / 1ps

interface gql_in_if
    import gql_pkg::*;
;
    logic              valid;
    logic              ready;
    t_action           action;
    logic [7:0]        char_code;
    logic [11:0]       atlas_x;
    logic [11:0]       atlas_y;
    logic [7:0]        glyph_width;
    logic [7:0]        glyph_height;
    logic signed [7:0] offset_x;
    logic signed [7:0] offset_y;
    logic [7:0]        advance;
    logic signed [31:0] pen_x;
    logic signed [31:0] pen_y;
    logic [15:0]       scale;

    modport source (
        output valid, action, char_code, atlas_x, atlas_y, glyph_width, glyph_height,
               offset_x, offset_y, advance, pen_x, pen_y, scale,
        input  ready
    );
    modport sink (
        input  valid, action, char_code, atlas_x, atlas_y, glyph_width, glyph_height,
               offset_x, offset_y, advance, pen_x, pen_y, scale,
        output ready
    );
endinterface

// ===== rtl/core/gql_out_if.sv =====
// gql_out_if: quad result channel out of the glyph quad layout block.
// Depends on gql_pkg only through the common import.
`timescale 1ns / 1ps

interface gql_out_if
    import gql_pkg::*;
;
    logic               valid;
    logic               ready;
    logic signed [31:0] quad_left;
    logic signed [31:0] quad_right;
    logic signed [31:0] quad_top;
    logic signed [31:0] quad_bottom;
    logic [15:0]        tex_left;
    logic [15:0]        tex_right;
    logic [15:0]        tex_low;
    logic [15:0]        tex_high;
    logic [7:0]         used_code;

    modport source (
        output valid, quad_left, quad_right, quad_top, quad_bottom,
               tex_left, tex_right, tex_low, tex_high, used_code,
        input  ready
    );
    modport sink (
        input  valid, quad_left, quad_right, quad_top, quad_bottom,
               tex_left, tex_right, tex_low, tex_high, used_code,
        output ready
    );
endinterface

// ===== rtl/core/glyph_quad_layout.sv =====
// glyph_quad_layout: text layout into textured quads, one character per request.
// Depends on gql_pkg, gql_in_if and gql_out_if.
//
// Takes one request per cycle unless stalled and returns the quad of a drawn
// character after table read, multiplies, pen update and edge sums. Throughput
// is one character per cycle unless stalled; the pen position carries from one
// draw to the next through a single register whose update is two chained
// saturating adds in the pen stage. The glyph table is a TABLE_ENTRIES-deep
// memory with one valid flop per entry, cleared at once by reset, so requests
// are taken from the first cycle after reset. Write and start requests and
// draws whose glyph and space glyph are both missing give no result. The
// output register decouples the result side: requests keep flowing until all
// stages hold an item and the result is not taken.
`timescale 1ns / 1ps

module glyph_quad_layout
    import gql_pkg::*;
#(
    parameter int TABLE_ENTRIES = 256
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    gql_in_if.sink                i_in,
    gql_out_if.source             o_out,
    input  logic                  i_cfg_we,
    input  t_cfg_idx              i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    // Configuration registers
    logic [23:0] r_inv_w;
    logic [12:0] r_height;
    logic [23:0] r_inv_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_w  <= INV_RESET;
            r_height <= HEIGHT_RESET;
            r_inv_h  <= INV_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_INV_W:  r_inv_w  <= i_cfg_data;
                CFG_HEIGHT: r_height <= i_cfg_data[12:0];
                CFG_INV_H:  r_inv_h  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stage enables, back to front
    logic r_a_vld, r_p_vld, r_b_vld, r_c_vld;
    logic en_a, en_p, en_b, en_c;

    assign en_c = !r_c_vld || o_out.ready;
    assign en_b = !r_b_vld || en_c;
    assign en_p = !r_p_vld || en_b;
    assign en_a = !r_a_vld || en_p;
    assign i_in.ready = en_a;

    // Request decode and table lookup with space fallback
    logic             acc;
    logic             in_range;
    logic [IDX_W-1:0] in_idx;
    logic [IDX_W-1:0] space_idx;
    logic             hit;
    logic             found;
    logic             is_write, is_start, is_draw;
    logic [IDX_W-1:0] rd_idx;

    assign acc       = i_in.valid && en_a;
    assign in_range  = 32'(i_in.char_code) < TABLE_ENTRIES;
    assign in_idx    = i_in.char_code[IDX_W-1:0];
    assign space_idx = SPACE_CODE[IDX_W-1:0];
    assign is_write  = i_in.action == ACT_WRITE;
    assign is_start  = i_in.action == ACT_START;
    assign is_draw   = i_in.action == ACT_DRAW;

    logic [TABLE_ENTRIES-1:0] r_valid;

    assign hit    = in_range && r_valid[in_idx];
    assign found  = hit || r_valid[space_idx];
    assign rd_idx = hit ? in_idx : space_idx;

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (acc && is_write && in_range) begin
            r_valid[in_idx] <= 1'b1;
        end
    end

    // Glyph table memory, registered read
    t_glyph r_mem [TABLE_ENTRIES];
    t_glyph r_mem_q;
    t_glyph wr_glyph;

    assign wr_glyph = '{ax: i_in.atlas_x, ay: i_in.atlas_y, w: i_in.glyph_width,
                        h: i_in.glyph_height, ox: i_in.offset_x, oy: i_in.offset_y,
                        adv: i_in.advance};

    always_ff @(posedge i_clk) begin
        if (acc && is_write && in_range) begin
            r_mem[in_idx] <= wr_glyph;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_mem_q <= r_mem[rd_idx];
        end
    end

    // Scale takes effect at accept, so each draw carries the scale it saw
    logic [15:0] r_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_ONE;
        end else if (acc && is_start) begin
            r_scale <= i_in.scale;
        end
    end

    // Stage A: request after table read
    logic        r_a_start;
    logic [7:0]  r_a_code;
    logic [15:0] r_a_scale;
    logic [31:0] r_a_pen_x;
    logic [31:0] r_a_pen_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (en_a) begin
            r_a_vld <= acc && (is_start || (is_draw && found));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a_start <= is_start;
            r_a_code  <= hit ? i_in.char_code : SPACE_CODE;
            r_a_scale <= r_scale;
            r_a_pen_x <= i_in.pen_x;
            r_a_pen_y <= i_in.pen_y;
        end
    end

    // Multiplies: scaled offsets and sizes, texel counts times reciprocals
    logic signed [24:0] ox_ext, oy_ext, sc_sext;
    logic [23:0]        w_ext, h_ext, adv_ext, sc_uext;
    logic [12:0]        tx_l, tx_r, ty_lo, ty_hi;
    logic signed [14:0] dy_hi, dy_lo;

    assign ox_ext  = 25'(r_mem_q.ox);
    assign oy_ext  = 25'(r_mem_q.oy);
    assign sc_sext = {9'd0, r_a_scale};
    assign w_ext   = {16'd0, r_mem_q.w};
    assign h_ext   = {16'd0, r_mem_q.h};
    assign adv_ext = {16'd0, r_mem_q.adv};
    assign sc_uext = {8'd0, r_a_scale};

    assign tx_l  = {1'b0, r_mem_q.ax};
    assign tx_r  = {1'b0, r_mem_q.ax} + {5'd0, r_mem_q.w};
    assign dy_hi = {2'b00, r_height} - {3'b000, r_mem_q.ay};
    assign dy_lo = dy_hi - {7'd0, r_mem_q.h};
    // Non-positive texel counts give a zero coordinate
    assign ty_hi = dy_hi[14] ? 13'd0 : dy_hi[12:0];
    assign ty_lo = dy_lo[14] ? 13'd0 : dy_lo[12:0];

    // Stage P: products
    logic               r_p_start;
    logic [7:0]         r_p_code;
    logic [31:0]        r_p_pen_x, r_p_pen_y;
    logic signed [24:0] r_p_ox, r_p_oy;
    logic [23:0]        r_p_w, r_p_h, r_p_adv;
    logic [36:0]        r_p_tl, r_p_tr, r_p_tlo, r_p_thi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else if (en_p) begin
            r_p_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_p) begin
            r_p_start <= r_a_start;
            r_p_code  <= r_a_code;
            r_p_pen_x <= r_a_pen_x;
            r_p_pen_y <= r_a_pen_y;
            r_p_ox    <= ox_ext * sc_sext;
            r_p_oy    <= oy_ext * sc_sext;
            r_p_w     <= w_ext * sc_uext;
            r_p_h     <= h_ext * sc_uext;
            r_p_adv   <= adv_ext * sc_uext;
            r_p_tl    <= {24'd0, tx_l}  * {13'd0, r_inv_w};
            r_p_tr    <= {24'd0, tx_r}  * {13'd0, r_inv_w};
            r_p_tlo   <= {24'd0, ty_lo} * {13'd0, r_inv_h};
            r_p_thi   <= {24'd0, ty_hi} * {13'd0, r_inv_h};
        end
    end

    // Pen loop: offset, emit, advance
    logic [31:0] r_pen, r_base;
    logic [31:0] n_x, n_y, n_pen;

    assign n_x   = sat32({{2{r_pen[31]}}, r_pen} + {r_p_ox[24], r_p_ox, 8'd0});
    assign n_y   = sat32({{2{r_base[31]}}, r_base} - {r_p_oy[24], r_p_oy, 8'd0});
    assign n_pen = sat32({{2{n_x[31]}}, n_x} + {2'b00, r_p_adv, 8'd0});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pen  <= '0;
            r_base <= '0;
        end else if (r_p_vld && en_b) begin
            if (r_p_start) begin
                r_pen  <= r_p_pen_x;
                r_base <= r_p_pen_y;
            end else begin
                r_pen  <= n_pen;
            end
        end
    end

    // Stage B: positions and clamped texture coordinates
    logic [31:0] r_b_x, r_b_y;
    logic [23:0] r_b_w, r_b_h;
    logic [15:0] r_b_tl, r_b_tr, r_b_tlo, r_b_thi;
    logic [7:0]  r_b_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (en_b) begin
            r_b_vld <= r_p_vld && !r_p_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_b) begin
            r_b_x    <= n_x;
            r_b_y    <= n_y;
            r_b_w    <= r_p_w;
            r_b_h    <= r_p_h;
            r_b_tl   <= tex_sat(r_p_tl);
            r_b_tr   <= tex_sat(r_p_tr);
            r_b_tlo  <= tex_sat(r_p_tlo);
            r_b_thi  <= tex_sat(r_p_thi);
            r_b_code <= r_p_code;
        end
    end

    // Stage C: far edges, output register
    logic [31:0] r_c_left, r_c_right, r_c_top, r_c_bottom;
    logic [15:0] r_c_tl, r_c_tr, r_c_tlo, r_c_thi;
    logic [7:0]  r_c_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (en_c) begin
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_c) begin
            r_c_left   <= r_b_x;
            r_c_right  <= sat32({{2{r_b_x[31]}}, r_b_x} + {2'b00, r_b_w, 8'd0});
            r_c_top    <= r_b_y;
            r_c_bottom <= sat32({{2{r_b_y[31]}}, r_b_y} - {2'b00, r_b_h, 8'd0});
            r_c_tl     <= r_b_tl;
            r_c_tr     <= r_b_tr;
            r_c_tlo    <= r_b_tlo;
            r_c_thi    <= r_b_thi;
            r_c_code   <= r_b_code;
        end
    end

    assign o_out.valid       = r_c_vld;
    assign o_out.quad_left   = r_c_left;
    assign o_out.quad_right  = r_c_right;
    assign o_out.quad_top    = r_c_top;
    assign o_out.quad_bottom = r_c_bottom;
    assign o_out.tex_left    = r_c_tl;
    assign o_out.tex_right   = r_c_tr;
    assign o_out.tex_low     = r_c_tlo;
    assign o_out.tex_high    = r_c_thi;
    assign o_out.used_code   = r_c_code;

    // Checks
    // table data for a held request must not move while stage A stalls
    a_mem_q_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_vld && !en_p |=> $stable(r_mem_q))
        else $error("table read data changed under a stalled request");

    // a draw in stage A always refers to a written entry
    a_draw_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_vld && !r_a_start |-> r_valid[r_a_code[IDX_W-1:0]])
        else $error("draw request carries an unwritten glyph code");

    // pen only moves when a request leaves the pen stage
    a_pen_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_p_vld && en_b) |=> $stable(r_pen))
        else $error("pen position changed without a request");

    // a bubble in stage B never produces a result
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_b_vld && en_c |=> !r_c_vld)
        else $error("result produced from an empty stage");

endmodule

// ===== verif/glyph_quad_layout_tb.sv =====
// glyph_quad_layout_tb: self-checking bench for the glyph quad layout block.
// Needs gql_pkg, gql_in_if, gql_out_if and glyph_quad_layout; reads nothing else.
// A directed table runs first, then random text under several atlas settings.
`timescale 1ns / 1ps

module glyph_quad_layout_tb;
    import gql_pkg::*;

    localparam int      CLK_HALF     = 2;
    localparam int      RESET_CYCLES = 12;
    localparam int      PHASES       = 6;
    localparam int      PHASE_REQS   = 175;
    localparam int      DRAIN_CYCLES = 12;
    localparam int      DRAIN_LIMIT  = 5000;
    localparam int      PRINT_CAP    = 50;
    localparam int      RUN_LIMIT_NS = 4_000_000;
    localparam longint  S32_MAX      = 64'sd2147483647;
    localparam longint  S32_MIN      = -64'sd2147483648;

    // Action code the block must ignore
    localparam t_action ACT_NONE = 2'd3;

    typedef struct packed {
        t_action            action;
        logic [7:0]         code;
        t_glyph             g;
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic [15:0]        scale;
    } t_req;

    typedef struct packed {
        logic signed [31:0] qleft;
        logic signed [31:0] qright;
        logic signed [31:0] qtop;
        logic signed [31:0] qbottom;
        logic [15:0]        uleft;
        logic [15:0]        uright;
        logic [15:0]        vlow;
        logic [15:0]        vhigh;
        logic [7:0]         code;
    } t_quad;

    typedef struct packed {
        t_req  r;
        logic  typed;
        t_quad q;
    } t_row;

    localparam t_quad NO_QUAD = '0;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    t_cfg_idx              cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    gql_in_if  in_if ();
    gql_out_if out_if ();

    glyph_quad_layout uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .o_out      (out_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Layout model state and atlas settings
    logic               glyph_ok [256];
    t_glyph             glyph_tab [256];
    logic signed [31:0] pen_x_q;
    logic signed [31:0] baseline_q;
    logic [15:0]        scale_q;
    logic [23:0]        inv_w_q;
    logic [12:0]        height_q;
    logic [23:0]        inv_h_q;

    t_quad quads_due [$];
    int    n_errors = 0;
    int    n_reqs   = 0;
    int    n_draws  = 0;
    int    n_quads  = 0;

    always begin
        i_clk = 1'b0;
        #CLK_HALF;
        i_clk = 1'b1;
        #CLK_HALF;
    end

    task automatic report_mismatch(input string msg);
        if (n_errors < PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
        n_errors++;
    endtask

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > S32_MAX) return 32'sh7FFF_FFFF;
        if (v < S32_MIN) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // Texel count to Q0.16 through a Q0.24 reciprocal, clamped at both ends
    function automatic logic [15:0] texel_uv(input longint texels, input logic [23:0] inv);
        longint p;
        if (texels <= 0) return 16'd0;
        p = (texels * longint'(inv)) >>> 8;
        return (p > 65535) ? 16'hFFFF : p[15:0];
    endfunction

    // One request through the layout model; drawn says whether a quad comes out
    function automatic void layout_step(input t_req r, output logic drawn, output t_quad q);
        t_glyph             g;
        logic [7:0]         code;
        longint             sc;
        logic signed [31:0] xs;
        logic signed [31:0] ys;
        drawn = 1'b0;
        q     = NO_QUAD;
        case (r.action)
            ACT_WRITE: begin
                glyph_tab[r.code] = r.g;
                glyph_ok[r.code]  = 1'b1;
            end
            ACT_START: begin
                pen_x_q    = r.px;
                baseline_q = r.py;
                scale_q    = r.scale;
            end
            ACT_DRAW: begin
                code = r.code;
                // missing code falls back to the space glyph
                if (!glyph_ok[code]) code = SPACE_CODE;
                if (glyph_ok[code]) begin
                    g  = glyph_tab[code];
                    sc = longint'(scale_q) * 256;
                    xs = clamp32(longint'(pen_x_q) + longint'($signed(g.ox)) * sc);
                    ys = clamp32(longint'(baseline_q) - longint'($signed(g.oy)) * sc);
                    q.qleft   = xs;
                    q.qright  = clamp32(longint'(xs) + longint'(g.w) * sc);
                    q.qtop    = ys;
                    q.qbottom = clamp32(longint'(ys) - longint'(g.h) * sc);
                    q.uleft   = texel_uv(longint'(g.ax), inv_w_q);
                    q.uright  = texel_uv(longint'(g.ax) + longint'(g.w), inv_w_q);
                    q.vlow    = texel_uv(longint'(height_q) - longint'(g.ay) - longint'(g.h),
                                         inv_h_q);
                    q.vhigh   = texel_uv(longint'(height_q) - longint'(g.ay), inv_h_q);
                    q.code    = code;
                    pen_x_q   = clamp32(longint'(xs) + longint'(g.adv) * sc);
                    drawn     = 1'b1;
                end
            end
            default: ;
        endcase
    endfunction

    // Mostly back to back, sometimes a short gap, rarely a long pause
    function automatic int unsigned pick_gap();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 55) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_req req_write(input logic [7:0] code, input logic [11:0] ax, ay,
                                       input logic [7:0] w, h, input logic signed [7:0] ox,
                                       oy, input logic [7:0] adv);
        t_req r;
        r        = '0;
        r.action = ACT_WRITE;
        r.code   = code;
        r.g      = '{ax, ay, w, h, ox, oy, adv};
        return r;
    endfunction

    function automatic t_req req_start(input logic signed [31:0] px, py,
                                       input logic [15:0] scale);
        t_req r;
        r        = '0;
        r.action = ACT_START;
        r.px     = px;
        r.py     = py;
        r.scale  = scale;
        return r;
    endfunction

    function automatic t_req req_draw(input logic [7:0] code);
        t_req r;
        r        = '0;
        r.action = ACT_DRAW;
        r.code   = code;
        return r;
    endfunction

    function automatic t_quad quad_of(input logic [31:0] ql, qr, qt, qb,
                                      input logic [15:0] ul, ur, vl, vh,
                                      input logic [7:0] code);
        return '{ql, qr, qt, qb, ul, ur, vl, vh, code};
    endfunction

    // Random request; writes and draws favour printable codes so lookups hit
    function automatic t_req rand_req();
        t_req           r;
        logic [159:0]   noise;
        int unsigned    pick;
        noise = {$urandom, $urandom, $urandom, $urandom, $urandom};
        r     = noise[$bits(t_req)-1:0];
        pick  = $urandom_range(0, 99);
        if (pick < 18) begin
            r.action = ACT_WRITE;
            if ($urandom_range(0, 3) != 0) r.code = 8'($urandom_range(32, 127));
        end else if (pick < 28) begin
            r.action = ACT_START;
            case ($urandom_range(0, 5))
                2, 3: begin
                    r.px = {{8{r.px[31]}}, r.px[23:0]};
                    r.py = {{8{r.py[31]}}, r.py[23:0]};
                end
                4: r.px = {16'h7FFF, r.px[15:0]};
                5: r.px = {16'h8000, r.px[15:0]};
                default: ;
            endcase
            case ($urandom_range(0, 7))
                0:       r.scale = 16'd0;
                1:       r.scale = 16'hFFFF;
                2, 3:    ;
                default: r.scale = 16'($urandom_range(64, 1024));
            endcase
        end else if (pick < 95) begin
            r.action = ACT_DRAW;
            if ($urandom_range(0, 4) != 0) r.code = 8'($urandom_range(32, 127));
        end else begin
            r.action = ACT_NONE;
        end
        return r;
    endfunction

    // Present one request, hold it until taken, then predict its quad
    task automatic send_req(input t_req r, input logic typed, input t_quad typed_q);
        logic  drawn;
        t_quad q;
        in_if.valid        <= 1'b1;
        in_if.action       <= r.action;
        in_if.char_code    <= r.code;
        in_if.atlas_x      <= r.g.ax;
        in_if.atlas_y      <= r.g.ay;
        in_if.glyph_width  <= r.g.w;
        in_if.glyph_height <= r.g.h;
        in_if.offset_x     <= r.g.ox;
        in_if.offset_y     <= r.g.oy;
        in_if.advance      <= r.g.adv;
        in_if.pen_x        <= r.px;
        in_if.pen_y        <= r.py;
        in_if.scale        <= r.scale;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        layout_step(r, drawn, q);
        if (typed) begin
            drawn = 1'b1;
            q     = typed_q;
        end
        if (drawn) begin
            quads_due.push_back(q);
            n_draws++;
        end
        n_reqs++;
    endtask

    task automatic idle_in(input int unsigned n);
        if (n != 0) begin
            in_if.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // Wait for every pending quad, then let the pipe empty of writes and starts
    task automatic settle();
        int unsigned spin;
        in_if.valid <= 1'b0;
        spin = 0;
        do begin
            @(posedge i_clk);
            spin++;
        end while (quads_due.size() != 0 && spin < DRAIN_LIMIT);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (quads_due.size() != 0) begin
            report_mismatch($sformatf("%0d quads never arrived", quads_due.size()));
            quads_due.delete();
        end
    endtask

    // Three back-to-back register writes, enable held high throughout
    task automatic program_atlas(input logic [23:0] inv_w, input logic [12:0] height,
                                 input logic [23:0] inv_h);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_INV_W;
        cfg_data <= inv_w;
        @(posedge i_clk);
        cfg_idx  <= CFG_HEIGHT;
        cfg_data <= CFG_DATA_W'(height);
        @(posedge i_clk);
        cfg_idx  <= CFG_INV_H;
        cfg_data <= inv_h;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        inv_w_q  = inv_w;
        height_q = height;
        inv_h_q  = inv_h;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
    endtask

    // Result side: ready runs of random length broken by stalls
    initial begin : result_side
        int unsigned run;
        int unsigned gap;
        forever begin
            out_if.ready <= 1'b1;
            run = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 20);
            repeat (run) @(posedge i_clk);
            gap = pick_gap();
            if (gap != 0) begin
                out_if.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    end

    // Compare each taken quad with the oldest prediction
    always @(posedge i_clk) begin : quad_monitor
        t_quad want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (quads_due.size() == 0) begin
                report_mismatch($sformatf("unexpected quad for code %0d", out_if.used_code));
            end else begin
                want = quads_due.pop_front();
                check_field("quad_left", out_if.quad_left, want.qleft);
                check_field("quad_right", out_if.quad_right, want.qright);
                check_field("quad_top", out_if.quad_top, want.qtop);
                check_field("quad_bottom", out_if.quad_bottom, want.qbottom);
                check_field("tex_left", out_if.tex_left, want.uleft);
                check_field("tex_right", out_if.tex_right, want.uright);
                check_field("tex_low", out_if.tex_low, want.vlow);
                check_field("tex_high", out_if.tex_high, want.vhigh);
                check_field("used_code", out_if.used_code, want.code);
                n_quads++;
            end
        end
    end

    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("run limit hit, %0d quads outstanding", quads_due.size());
        $display("** glyph_quad_layout: FAILED **");
        $finish;
    end

    initial begin : stimulus
        t_row        dir_rows [$];
        t_req        r;
        t_req        nz;
        t_quad       q_a;
        int          counted;
        logic        burst;
        int unsigned w_tex;
        int unsigned h_tex;

        // Known values on every input from time zero
        in_if.valid        <= 1'b0;
        in_if.action       <= ACT_WRITE;
        in_if.char_code    <= '0;
        in_if.atlas_x      <= '0;
        in_if.atlas_y      <= '0;
        in_if.glyph_width  <= '0;
        in_if.glyph_height <= '0;
        in_if.offset_x     <= '0;
        in_if.offset_y     <= '0;
        in_if.advance      <= '0;
        in_if.pen_x        <= '0;
        in_if.pen_y        <= '0;
        in_if.scale        <= '0;
        cfg_we             <= 1'b0;
        cfg_idx            <= CFG_INV_W;
        cfg_data           <= '0;
        i_rst_n            <= 1'b0;

        // Model reset state
        foreach (glyph_ok[i]) glyph_ok[i] = 1'b0;
        pen_x_q    = '0;
        baseline_q = '0;
        scale_q    = SCALE_ONE;
        inv_w_q    = INV_RESET;
        height_q   = HEIGHT_RESET;
        inv_h_q    = INV_RESET;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table, run under the reset atlas settings
        q_a = quad_of(32'h0, 32'h8_0000, 32'h0, 32'hFFF0_0000, 16'd4096, 16'd6144,
                      16'd61440, 16'd65535, 8'd65);
        nz        = rand_req();
        nz.action = ACT_NONE;
        // nothing in the table yet: no glyph, no space
        dir_rows.push_back('{req_draw(8'd65), 1'b0, NO_QUAD});
        dir_rows.push_back('{req_write(8'd65, 12'd16, 12'd0, 8'd8, 8'd16, 8'sd0, 8'sd0, 8'd8),
                             1'b0, NO_QUAD});
        dir_rows.push_back('{req_draw(8'd65), 1'b1, q_a});
        // pen has moved on by eight texels
        q_a.qleft  = 32'h8_0000;
        q_a.qright = 32'h10_0000;
        dir_rows.push_back('{req_draw(8'd65), 1'b1, q_a});
        dir_rows.push_back('{req_draw(8'd66), 1'b0, NO_QUAD});
        dir_rows.push_back('{nz, 1'b0, NO_QUAD});
        dir_rows.push_back('{req_write(SPACE_CODE, 12'd0, 12'd0, 8'd0, 8'd0, 8'sd0, 8'sd0,
                                       8'd4), 1'b0, NO_QUAD});
        dir_rows.push_back('{req_draw(8'd66), 1'b0, NO_QUAD});
        dir_rows.push_back('{req_write(8'd255, 12'd4095, 12'd4095, 8'd255, 8'd255, -8'sd128,
                                       8'sd127, 8'd255), 1'b0, NO_QUAD});
        dir_rows.push_back('{req_write(8'd0, 12'd0, 12'd0, 8'd0, 8'd0, 8'sd127, -8'sd128,
                                       8'd0), 1'b0, NO_QUAD});
        // pen near the top, baseline at the bottom, largest scale: edges clamp
        dir_rows.push_back('{req_start(32'sh7FFF_0000, 32'sh8000_0000, 16'hFFFF),
                             1'b0, NO_QUAD});
        dir_rows.push_back('{req_draw(8'd65), 1'b1,
                             quad_of(32'h7FFF_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                                     32'h8000_0000, 16'd4096, 16'd6144, 16'd61440,
                                     16'd65535, 8'd65)});
        dir_rows.push_back('{req_draw(8'd255), 1'b0, NO_QUAD});
        dir_rows.push_back('{req_draw(8'd0), 1'b0, NO_QUAD});
        dir_rows.push_back('{req_start(32'sh8000_0000, 32'sh7FFF_FFFF, 16'hFFFF),
                             1'b0, NO_QUAD});
        dir_rows.push_back('{req_draw(8'd255), 1'b0, NO_QUAD});
        dir_rows.push_back('{req_draw(8'd0), 1'b0, NO_QUAD});
        // zero scale collapses the quad; atlas corner gives clamped uv
        dir_rows.push_back('{req_start(32'sh0, 32'sh0, 16'd0), 1'b0, NO_QUAD});
        dir_rows.push_back('{req_draw(8'd255), 1'b1,
                             quad_of(32'h0, 32'h0, 32'h0, 32'h0, 16'd65535, 16'd65535,
                                     16'd0, 16'd0, 8'd255)});
        dir_rows.push_back('{req_draw(8'd200), 1'b0, NO_QUAD});
        dir_rows.push_back('{req_start(32'sh1_0000, 32'sh10_0000, SCALE_ONE), 1'b0, NO_QUAD});
        dir_rows.push_back('{req_draw(8'd65), 1'b0, NO_QUAD});
        dir_rows.push_back('{req_draw(SPACE_CODE), 1'b0, NO_QUAD});

        foreach (dir_rows[i]) begin
            send_req(dir_rows[i].r, dir_rows[i].typed, dir_rows[i].q);
            idle_in(pick_gap());
        end

        // Random text, one atlas setting per phase
        for (int p = 0; p < PHASES; p++) begin
            settle();
            case (p)
                0: program_atlas(24'hFF_FFFF, 13'd4096, 24'hFF_FFFF);
                1: program_atlas(24'd0, 13'd1, 24'd0);
                2: program_atlas(24'($urandom), 13'd8191, 24'($urandom));
                3: program_atlas(24'd16384, 13'd1024, 24'd16384);
                4: program_atlas(24'($urandom), 13'd0, 24'($urandom));
                default: begin
                    w_tex = $urandom_range(1, 4096);
                    h_tex = $urandom_range(1, 4096);
                    program_atlas(24'((1 << 24) / w_tex), 13'(h_tex), 24'((1 << 24) / h_tex));
                end
            endcase
            counted = 0;
            burst   = 1'b0;
            while (counted < PHASE_REQS) begin
                if (counted % 40 == 0) burst = ($urandom_range(0, 3) == 0);
                r = rand_req();
                send_req(r, 1'b0, NO_QUAD);
                if (r.action != ACT_NONE) counted++;
                idle_in(burst ? 0 : pick_gap());
            end
        end

        settle();
        $display("Sent %0d requests, %0d of them drawing; %0d quads checked field by field.",
                 n_reqs, n_draws, n_quads);
        $display("Atlas settings covered: reset values plus %0d programmed sets.", PHASES);
        if (n_errors == 0) begin
            $display("** glyph_quad_layout: PASSED **");
        end else begin
            $display("%0d mismatches in total", n_errors);
            $display("** glyph_quad_layout: FAILED **");
        end
        $finish;
    end

endmodule

// ===== glyph_quad_layout.f =====
rtl/core/gql_pkg.sv
rtl/core/gql_in_if.sv
rtl/core/gql_out_if.sv
rtl/core/glyph_quad_layout.sv
verif/glyph_quad_layout_tb.sv
